// ===== hw/rtl/kcrt_pkg.sv =====
package kcrt_pkg;

   localparam int SLOTS   = 1024;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int DEPTH   = 2 * SLOTS;
   localparam int ADDR_W  = SLOT_W + 1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_ROUND  = 1'b1;

   localparam logic [14:0] PCT_FULL = 15'd25600;
   localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [63:0] busy;
      logic [63:0] total;
      logic [63:0] bytes;
      logic [31:0] faults;
      logic [63:0] tms;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CHK,
      ST_LK_RD,
      ST_LK_CHK,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SEL_PCT,
      SEL_BYTE,
      SEL_FAULT
   } sel_type;

   typedef struct packed {
      logic    load;
      logic    round_start;
      logic    clr_step;
      logic    probe_start;
      logic    probe_next;
      logic    rd_en;
      logic    rd_prev;
      logic    wr_entry;
      logic    capture;
      logic    mul;
      sel_type sel;
      logic    div_step;
      logic    commit;
   } cmd_type;

   typedef struct packed {
      logic is_round;
      logic clr_done;
      logic rd_valid;
      logic rd_match;
      logic probe_last;
      logic skip;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/kcrt_ram.sv =====
module kcrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/kcrt_datapath.sv =====
module kcrt_datapath (
   input  logic                clock,
   input  logic                reset,
   input  kcrt_pkg::cmd_type   cmd,
   output kcrt_pkg::status_type status,
   input  logic                req_opcode,
   input  logic [31:0]         req_item_id,
   input  logic [63:0]         req_busy_time,
   input  logic [63:0]         req_total_time,
   input  logic [63:0]         req_byte_count,
   input  logic [31:0]         req_fault_count,
   input  logic [63:0]         req_time_ms,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_had_previous,
   output logic                rsp_stored,
   output logic [14:0]         rsp_busy_percent,
   output logic [63:0]         rsp_byte_rate,
   output logic [31:0]         rsp_fault_rate
);

   localparam int SW = kcrt_pkg::SLOT_W;
   localparam int AW = kcrt_pkg::ADDR_W;

   // input item
   logic        op_ff;
   logic [31:0] id_ff;
   logic [63:0] busy_ff, total_ff, bytes_ff, tms_ff;
   logic [31:0] faults_ff;

   // table control
   logic          bank_ff, bank_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW:0]   clr_left_ff, clr_left_in;
   logic [SW-1:0] s_ff, s_in, n_ff, n_in;

   // deltas of the found entry
   logic [63:0] dbusy_ff, dtot_ff, dms_ff, dbytes_ff;
   logic [31:0] dfault_ff;

   // divider
   logic [64:0] rem_ff;
   logic [63:0] lo_ff, den_ff, q_ff;
   logic [5:0]  cnt_ff;

   // result
   logic        found_ff, stored_ff;
   logic [14:0] pct_ff;
   logic [63:0] brate_ff;
   logic [31:0] frate_ff;
   logic        rsp_valid_ff;
   logic        out_had_ff, out_stored_ff;
   logic [14:0] out_pct_ff;
   logic [63:0] out_brate_ff;
   logic [31:0] out_frate_ff;

   kcrt_pkg::entry_type rd_entry, wr_entry;
   logic [kcrt_pkg::ENTRY_W-1:0] rd_raw;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;

   logic [79:0] prod;
   logic [63:0] mul_src;
   logic [63:0] mul_den;
   logic        skip;
   logic [64:0] sh;
   logic        ge;
   logic [63:0] q_next;

   kcrt_ram #(
      .WIDTH(kcrt_pkg::ENTRY_W),
      .DEPTH(kcrt_pkg::DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   assign rd_entry = kcrt_pkg::entry_type'(rd_raw);

   always_comb begin
      wr_en    = cmd.clr_step | cmd.wr_entry;
      wr_addr  = clr_addr_ff;
      wr_entry = '0;
      if (cmd.wr_entry) begin
         wr_addr         = {bank_ff, s_ff};
         wr_entry.valid  = 1'b1;
         wr_entry.key    = id_ff;
         wr_entry.busy   = busy_ff;
         wr_entry.total  = total_ff;
         wr_entry.bytes  = bytes_ff;
         wr_entry.faults = faults_ff;
         wr_entry.tms    = tms_ff;
      end
   end

   assign rd_addr = {bank_ff ^ cmd.rd_prev, s_ff};

   // clear pass and probe counters
   always_comb begin
      bank_in     = bank_ff;
      clr_addr_in = clr_addr_ff;
      clr_left_in = clr_left_ff;
      s_in        = s_ff;
      n_in        = n_ff;
      if (cmd.round_start) begin
         bank_in     = ~bank_ff;
         clr_addr_in = {~bank_ff, {SW{1'b0}}};
         clr_left_in = (AW+1)'(kcrt_pkg::SLOTS);
      end else if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         clr_left_in = clr_left_ff - 1'b1;
      end
      if (cmd.probe_start) begin
         s_in = SW'(id_ff % kcrt_pkg::SLOTS);
         n_in = '0;
      end else if (cmd.load) begin
         s_in = SW'(req_item_id % kcrt_pkg::SLOTS);
         n_in = '0;
      end else if (cmd.probe_next) begin
         s_in = s_ff + 1'b1;
         n_in = n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff     <= 1'b0;
         clr_addr_ff <= '0;
         clr_left_ff <= (AW+1)'(kcrt_pkg::DEPTH);
         op_ff       <= kcrt_pkg::OP_SAMPLE;
      end else begin
         bank_ff     <= bank_in;
         clr_addr_ff <= clr_addr_in;
         clr_left_ff <= clr_left_in;
         if (cmd.load) begin
            op_ff <= req_opcode;
         end
      end
      s_ff <= s_in;
      n_ff <= n_in;
   end

   // multiplier by a constant and trivial cases
   always_comb begin
      mul_src = {32'd0, dfault_ff};
      mul_den = dms_ff;
      case (cmd.sel)
         kcrt_pkg::SEL_PCT: begin
            mul_src = dbusy_ff;
            mul_den = dtot_ff;
         end
         kcrt_pkg::SEL_BYTE: begin
            mul_src = dbytes_ff;
         end
         default: begin
            mul_src = {32'd0, dfault_ff};
         end
      endcase
      if (cmd.sel == kcrt_pkg::SEL_PCT) begin
         prod = ({16'd0, mul_src} << 14) + ({16'd0, mul_src} << 13)
              + ({16'd0, mul_src} << 10);
      end else begin
         prod = ({16'd0, mul_src} << 10) - ({16'd0, mul_src} << 4)
              - ({16'd0, mul_src} << 3);
      end
      skip = (mul_den == 64'd0) || ({48'd0, prod[79:64]} >= mul_den)
          || (cmd.sel == kcrt_pkg::SEL_PCT && dbusy_ff >= dtot_ff);
   end

   // one quotient bit per step
   always_comb begin
      sh     = {rem_ff[63:0], lo_ff[63]};
      ge     = sh >= {1'b0, den_ff};
      q_next = {q_ff[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff     <= req_item_id;
         busy_ff   <= req_busy_time;
         total_ff  <= req_total_time;
         bytes_ff  <= req_byte_count;
         faults_ff <= req_fault_count;
         tms_ff    <= req_time_ms;
         found_ff  <= 1'b0;
         stored_ff <= 1'b0;
         pct_ff    <= '0;
         brate_ff  <= '0;
         frate_ff  <= '0;
      end
      if (cmd.wr_entry) begin
         stored_ff <= 1'b1;
      end
      if (cmd.capture) begin
         found_ff  <= 1'b1;
         dbusy_ff  <= busy_ff - rd_entry.busy;
         dtot_ff   <= total_ff - rd_entry.total;
         dms_ff    <= tms_ff - rd_entry.tms;
         dbytes_ff <= bytes_ff - rd_entry.bytes;
         dfault_ff <= (faults_ff >= rd_entry.faults) ? faults_ff - rd_entry.faults : 32'd0;
      end
      if (cmd.mul) begin
         rem_ff <= {49'd0, prod[79:64]};
         lo_ff  <= prod[63:0];
         den_ff <= mul_den;
         q_ff   <= '0;
         cnt_ff <= '0;
         if (skip) begin
            case (cmd.sel)
               kcrt_pkg::SEL_PCT: begin
                  pct_ff <= (dtot_ff == 64'd0) ? 15'd0 : kcrt_pkg::PCT_FULL;
               end
               kcrt_pkg::SEL_BYTE: begin
                  brate_ff <= (mul_den == 64'd0) ? 64'd0 : {64{1'b1}};
               end
               default: begin
                  frate_ff <= (mul_den == 64'd0) ? 32'd0 : kcrt_pkg::MAX32;
               end
            endcase
         end
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? sh - {1'b0, den_ff} : sh;
         lo_ff  <= {lo_ff[62:0], 1'b0};
         q_ff   <= q_next;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == 6'd63) begin
            case (cmd.sel)
               kcrt_pkg::SEL_PCT: begin
                  pct_ff <= q_next[14:0];
               end
               kcrt_pkg::SEL_BYTE: begin
                  brate_ff <= q_next;
               end
               default: begin
                  frate_ff <= (q_next[63:32] != 32'd0) ? kcrt_pkg::MAX32 : q_next[31:0];
               end
            endcase
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         out_had_ff    <= found_ff;
         out_stored_ff <= stored_ff;
         out_pct_ff    <= pct_ff;
         out_brate_ff  <= brate_ff;
         out_frate_ff  <= frate_ff;
      end
   end

   assign status.is_round   = op_ff == kcrt_pkg::OP_ROUND;
   assign status.clr_done   = clr_left_ff == (AW+1)'(1);
   assign status.rd_valid   = rd_entry.valid;
   assign status.rd_match   = rd_entry.key == id_ff;
   assign status.probe_last = n_ff == SW'(kcrt_pkg::SLOTS - 1);
   assign status.skip       = skip;
   assign status.div_done   = cnt_ff == 6'd63;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_had_previous = out_had_ff;
   assign rsp_stored       = out_stored_ff;
   assign rsp_busy_percent = out_pct_ff;
   assign rsp_byte_rate    = out_brate_ff;
   assign rsp_fault_rate   = out_frate_ff;

endmodule

// ===== hw/rtl/kcrt_ctrl.sv =====
module kcrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kcrt_pkg::status_type status,
   output kcrt_pkg::cmd_type    cmd
);

   kcrt_pkg::state_type state_ff, state_in;
   kcrt_pkg::sel_type   sel_ff, sel_in;
   logic                last_sel;

   assign last_sel = sel_ff == kcrt_pkg::SEL_FAULT;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         kcrt_pkg::ST_CLEAR: begin
            if (status.clr_done) begin
               state_in = status.is_round ? kcrt_pkg::ST_DONE : kcrt_pkg::ST_IDLE;
            end
         end
         kcrt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kcrt_pkg::ST_INS_RD;
            end
         end
         kcrt_pkg::ST_INS_RD: begin
            state_in = status.is_round ? kcrt_pkg::ST_CLEAR : kcrt_pkg::ST_INS_CHK;
         end
         kcrt_pkg::ST_INS_CHK: begin
            if (!status.rd_valid || status.rd_match || status.probe_last) begin
               state_in = kcrt_pkg::ST_LK_RD;
            end else begin
               state_in = kcrt_pkg::ST_INS_RD;
            end
         end
         kcrt_pkg::ST_LK_RD: begin
            state_in = kcrt_pkg::ST_LK_CHK;
         end
         kcrt_pkg::ST_LK_CHK: begin
            if (!status.rd_valid) begin
               state_in = kcrt_pkg::ST_DONE;
            end else if (status.rd_match) begin
               state_in = kcrt_pkg::ST_MUL;
               sel_in   = kcrt_pkg::SEL_PCT;
            end else if (status.probe_last) begin
               state_in = kcrt_pkg::ST_DONE;
            end else begin
               state_in = kcrt_pkg::ST_LK_RD;
            end
         end
         kcrt_pkg::ST_MUL: begin
            if (!status.skip) begin
               state_in = kcrt_pkg::ST_DIV;
            end else if (last_sel) begin
               state_in = kcrt_pkg::ST_DONE;
            end else begin
               sel_in = (sel_ff == kcrt_pkg::SEL_PCT) ? kcrt_pkg::SEL_BYTE : kcrt_pkg::SEL_FAULT;
            end
         end
         kcrt_pkg::ST_DIV: begin
            if (status.div_done) begin
               if (last_sel) begin
                  state_in = kcrt_pkg::ST_DONE;
               end else begin
                  state_in = kcrt_pkg::ST_MUL;
                  sel_in   = (sel_ff == kcrt_pkg::SEL_PCT) ? kcrt_pkg::SEL_BYTE
                                                           : kcrt_pkg::SEL_FAULT;
               end
            end
         end
         kcrt_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = kcrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kcrt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.sel   = sel_ff;
      req_ready = 1'b0;
      case (state_ff)
         kcrt_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         kcrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         kcrt_pkg::ST_INS_RD: begin
            cmd.rd_en       = !status.is_round;
            cmd.round_start = status.is_round;
         end
         kcrt_pkg::ST_INS_CHK: begin
            if (!status.rd_valid || status.rd_match) begin
               cmd.wr_entry    = 1'b1;
               cmd.probe_start = 1'b1;
            end else if (status.probe_last) begin
               cmd.probe_start = 1'b1;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         kcrt_pkg::ST_LK_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_prev = 1'b1;
         end
         kcrt_pkg::ST_LK_CHK: begin
            cmd.capture    = status.rd_valid && status.rd_match;
            cmd.probe_next = status.rd_valid && !status.rd_match;
         end
         kcrt_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         kcrt_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         kcrt_pkg::ST_DONE: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kcrt_pkg::ST_CLEAR;
         sel_ff   <= kcrt_pkg::SEL_PCT;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

// ===== hw/rtl/keyed_counter_rate_tracker_top.sv =====
// sample item: an accept state, then a read and a check per slot probed on insert and again on
//   lookup, then on a hit each rate is either set directly or computed by the divider,
//   and a commit state; the result is valid the cycle after commit
// new-round item: nearly all of its time goes to clearing the SLOTS entries of the new bank
// one item at a time; a finished result waits in the output register until taken
// reset: clearing pass over both banks (2 * SLOTS entries), no item taken
module keyed_counter_rate_tracker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_item_id,
   input  logic [63:0] req_busy_time,
   input  logic [63:0] req_total_time,
   input  logic [63:0] req_byte_count,
   input  logic [31:0] req_fault_count,
   input  logic [63:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_had_previous,
   output logic        rsp_stored,
   output logic [14:0] rsp_busy_percent,
   output logic [63:0] rsp_byte_rate,
   output logic [31:0] rsp_fault_rate
);

   // command and status between sequencer and datapath
   kcrt_pkg::cmd_type    cmd;
   kcrt_pkg::status_type status;

   // sequencer: clear pass, probe walk, division steps
   kcrt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // datapath: slot memory, deltas, divider, result register
   kcrt_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_opcode),
      .req_item_id     (req_item_id),
      .req_busy_time   (req_busy_time),
      .req_total_time  (req_total_time),
      .req_byte_count  (req_byte_count),
      .req_fault_count (req_fault_count),
      .req_time_ms     (req_time_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_had_previous(rsp_had_previous),
      .rsp_stored      (rsp_stored),
      .rsp_busy_percent(rsp_busy_percent),
      .rsp_byte_rate   (rsp_byte_rate),
      .rsp_fault_rate  (rsp_fault_rate)
   );

endmodule
